// File: hw/rtl/fbpa_pkg.sv
// ----------------------------------------------------------------------------
// fbpa_pkg
// shared widths, codes and helpers of the fixed block pool allocator
// ----------------------------------------------------------------------------
package fbpa_pkg;

  localparam int MAX_BLOCKS  = 256;
  localparam int ROUND_BYTES = 4;
  localparam int ADDR_W      = 32;

  localparam int IDX_W    = $clog2(MAX_BLOCKS);        // block index
  localparam int CNT_W    = $clog2(MAX_BLOCKS + 1);    // block count, free count
  localparam int SIZE_W   = 16;                        // block_size register
  localparam int STRIDE_W = SIZE_W + 1;                // rounded block size
  localparam int QUO_W    = IDX_W + 1;                 // release quotient
  localparam int STEP_W   = $clog2(QUO_W);             // step counter
  localparam int LINK_W   = IDX_W + 1;                 // link entry: valid + index
  localparam int STAT_W   = 2;
  localparam int CFG_IDX_W = 2;

  // status codes
  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] ST_BAD   = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_POOL_BASE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_SIZE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_COUNT = 2'd2;

  // operation codes
  localparam logic FUNC_ALLOC   = 1'b0;
  localparam logic FUNC_RELEASE = 1'b1;

  // block size rounded up to the word unit, zero treated as one byte
  function automatic logic [STRIDE_W-1:0] calc_stride(input logic [SIZE_W-1:0] size);
    logic [STRIDE_W-1:0] s;
    s = (size == '0) ? STRIDE_W'(1) : {1'b0, size};
    return STRIDE_W'(((s + STRIDE_W'(ROUND_BYTES - 1)) / STRIDE_W'(ROUND_BYTES))
                     * STRIDE_W'(ROUND_BYTES));
  endfunction

  // block count saturated to the pool capacity
  function automatic logic [CNT_W-1:0] calc_count(input logic [8:0] count);
    logic [CNT_W-1:0] c;
    c = (32'(count) > MAX_BLOCKS) ? CNT_W'(MAX_BLOCKS) : CNT_W'(count);
    return c;
  endfunction

endpackage

// File: hw/rtl/fbpa_alu.sv
// ----------------------------------------------------------------------------
// fbpa_alu
// shared add / subtract unit with carry out, used by the multiply, offset, range check and divide steps
// ----------------------------------------------------------------------------
module fbpa_alu (
  input  logic [fbpa_pkg::ADDR_W-1:0] op_a,
  input  logic [fbpa_pkg::ADDR_W-1:0] op_b,
  input  logic                        sub,
  output logic [fbpa_pkg::ADDR_W-1:0] result,
  output logic                        carry    // on subtract: op_a >= op_b
);

  logic [fbpa_pkg::ADDR_W:0] sum;
  logic [fbpa_pkg::ADDR_W-1:0] b_in;

  always_comb begin
    b_in = sub ? ~op_b : op_b;
    sum  = {1'b0, op_a} + {1'b0, b_in} + {{fbpa_pkg::ADDR_W{1'b0}}, sub};
  end

  assign result = sum[fbpa_pkg::ADDR_W-1:0];
  assign carry  = sum[fbpa_pkg::ADDR_W];

endmodule

// File: hw/rtl/fbpa_link_ram.sv
// ----------------------------------------------------------------------------
// fbpa_link_ram
// single write port, single registered read port RAM for the free list links
// ----------------------------------------------------------------------------
module fbpa_link_ram #(
  parameter int AW = 8,
  parameter int DW = 9
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data
);

  logic [DW-1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: hw/rtl/fixed_block_pool_allocator.sv
// ----------------------------------------------------------------------------
// fixed_block_pool_allocator
// one pool of equal-sized blocks: LIFO free list plus a bump index
// ----------------------------------------------------------------------------
// sequence: allocate goes through S_ALOC alone when empty, then S_MUL off the bump
//   index, or S_LINK and S_MUL off the free list; release through S_OFS and S_CHK when
//   far out of range, else on through S_DIV and S_REL; one transaction at a time, the
//   next input is taken the cycle after the result moves to the output register, which
//   waits while m_tready holds it; the shared adder runs the shift-add multiply (8 steps) and the divide (9 steps)
// reset: synchronous; empty free list, 256 free blocks, link RAM not cleared
// ----------------------------------------------------------------------------
module fixed_block_pool_allocator (
  input  logic                              clk,
  input  logic                              rst,
  // input stream
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [31:0]                       s_tdata,   // [31:0] block_addr
  input  logic                              s_tuser,   // [0] func
  // result stream
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [47:0]                       m_tdata,   // [1:0] status, [33:2] granted_addr,
                                                       // [42:34] free_blocks, rest zero
  // configuration write channel
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [fbpa_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [31:0]                       cfg_data
);

  // sequencer states
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_ALOC  = 3'd1;  // pick list head or bump index
  localparam logic [2:0] S_LINK  = 3'd2;  // link RAM data back, pop head
  localparam logic [2:0] S_MUL   = 3'd3;  // granted = base + idx * stride
  localparam logic [2:0] S_OFS   = 3'd4;  // offset = addr - base
  localparam logic [2:0] S_CHK   = 3'd5;  // quick range check against stride << 9
  localparam logic [2:0] S_DIV   = 3'd6;  // restoring divide, one quotient bit a cycle
  localparam logic [2:0] S_REL   = 3'd7;  // final checks, push onto the list

  localparam int AW = fbpa_pkg::ADDR_W;

  // configuration registers
  logic [AW-1:0]                  pool_base;
  logic [fbpa_pkg::SIZE_W-1:0]    block_size;
  logic [8:0]                     block_count;

  // pool state
  logic [fbpa_pkg::IDX_W-1:0]     free_head;
  logic                           head_valid;
  logic [fbpa_pkg::CNT_W-1:0]     unused_index;
  logic [fbpa_pkg::CNT_W-1:0]     free_count;

  // sequencer and datapath registers
  logic [2:0]                     state;
  logic                           done;       // result ready to be moved to output
  logic                           op;
  logic [AW-1:0]                  addr;
  logic [AW-1:0]                  acc;        // remainder on release, address on allocate
  logic [fbpa_pkg::QUO_W-1:0]     quo;
  logic [fbpa_pkg::IDX_W-1:0]     idx;
  logic [fbpa_pkg::STEP_W-1:0]    step;
  logic [fbpa_pkg::STAT_W-1:0]    status;

  // derived configuration
  logic [fbpa_pkg::STRIDE_W-1:0]  stride;
  logic [fbpa_pkg::CNT_W-1:0]     count;

  assign stride = fbpa_pkg::calc_stride(block_size);
  assign count  = fbpa_pkg::calc_count(block_count);

  // shared adder
  logic [AW-1:0] alu_a;
  logic [AW-1:0] alu_b;
  logic          alu_sub;
  logic [AW-1:0] alu_res;
  logic          alu_carry;
  logic [AW-1:0] stride_sh;

  assign stride_sh = AW'(stride) << step;

  always_comb begin
    alu_a   = acc;
    alu_b   = stride_sh;
    alu_sub = 1'b1;
    case (state)
      S_MUL: begin
        alu_sub = 1'b0;
        alu_b   = idx[step[fbpa_pkg::STEP_W-2:0]] ? stride_sh : '0;
      end
      S_OFS: begin
        alu_a = addr;
        alu_b = pool_base;
      end
      S_CHK: begin
        alu_b = AW'(stride) << fbpa_pkg::QUO_W;
      end
      default: begin
        alu_b = stride_sh;
      end
    endcase
  end

  fbpa_alu u_alu (
    .op_a   (alu_a),
    .op_b   (alu_b),
    .sub    (alu_sub),
    .result (alu_res),
    .carry  (alu_carry)
  );

  // free list link store
  logic                        ram_wr_en;
  logic [fbpa_pkg::LINK_W-1:0] ram_rd_data;
  logic                        rel_bad;

  assign rel_bad = (free_count >= count) || (quo >= fbpa_pkg::QUO_W'(count)) || (acc != '0);
  assign ram_wr_en = (state == S_REL) && !rel_bad;

  fbpa_link_ram #(
    .AW (fbpa_pkg::IDX_W),
    .DW (fbpa_pkg::LINK_W)
  ) u_link_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (quo[fbpa_pkg::IDX_W-1:0]),
    .wr_data ({head_valid, free_head}),
    .rd_en   (state == S_ALOC),
    .rd_addr (free_head),
    .rd_data (ram_rd_data)
  );

  // handshakes: config is always taken, input only when the sequencer is idle with no result waiting
  assign cfg_ready = 1'b1;
  assign s_tready  = (state == S_IDLE) && !done;

  logic out_load;
  assign out_load = done && (!m_tvalid || m_tready);

  // new block count as seen by a pool re-init on a config write
  logic [fbpa_pkg::CNT_W-1:0] cfg_count;
  assign cfg_count = (cfg_index == fbpa_pkg::CFG_BLOCK_COUNT) ?
                     fbpa_pkg::calc_count(cfg_data[8:0]) : count;

  always_ff @(posedge clk) begin
    if (rst) begin
      pool_base    <= '0;
      block_size   <= fbpa_pkg::SIZE_W'(4);
      block_count  <= 9'(fbpa_pkg::MAX_BLOCKS);
      free_head    <= '0;
      head_valid   <= 1'b0;
      unused_index <= '0;
      free_count   <= fbpa_pkg::CNT_W'(fbpa_pkg::MAX_BLOCKS);
      state        <= S_IDLE;
      done         <= 1'b0;
      m_tvalid     <= 1'b0;
    end else begin
      // output register
      if (out_load) begin
        m_tvalid <= 1'b1;
        done     <= 1'b0;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end

      // a valid config write to pool_base, block_size or block_count re-initializes the pool
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == fbpa_pkg::CFG_POOL_BASE || cfg_index == fbpa_pkg::CFG_BLOCK_SIZE ||
            cfg_index == fbpa_pkg::CFG_BLOCK_COUNT) begin
          head_valid   <= 1'b0;
          free_head    <= '0;
          unused_index <= '0;
          free_count   <= cfg_count;
        end
        unique case (cfg_index)
          fbpa_pkg::CFG_POOL_BASE:   pool_base   <= cfg_data;
          fbpa_pkg::CFG_BLOCK_SIZE:  block_size  <= cfg_data[fbpa_pkg::SIZE_W-1:0];
          fbpa_pkg::CFG_BLOCK_COUNT: block_count <= cfg_data[8:0];
          default: ;
        endcase
      end

      unique case (state)
        S_IDLE: begin
          if (s_tvalid && s_tready) begin
            op    <= s_tuser;
            addr  <= s_tdata;
            state <= (s_tuser == fbpa_pkg::FUNC_RELEASE) ? S_OFS : S_ALOC;
          end
        end
        S_ALOC: begin
          acc  <= pool_base;
          step <= fbpa_pkg::STEP_W'(fbpa_pkg::IDX_W - 1);
          if (free_count != '0 && head_valid) begin
            idx   <= free_head;
            state <= S_LINK;
          end else if (free_count != '0 && unused_index < count) begin
            idx          <= unused_index[fbpa_pkg::IDX_W-1:0];
            unused_index <= unused_index + fbpa_pkg::CNT_W'(1);
            free_count   <= free_count - fbpa_pkg::CNT_W'(1);
            state        <= S_MUL;
          end else begin
            status <= fbpa_pkg::ST_EMPTY;
            done   <= 1'b1;
            state  <= S_IDLE;
          end
        end
        S_LINK: begin
          free_head  <= ram_rd_data[fbpa_pkg::IDX_W-1:0];
          head_valid <= ram_rd_data[fbpa_pkg::IDX_W];
          free_count <= free_count - fbpa_pkg::CNT_W'(1);
          state      <= S_MUL;
        end
        S_MUL: begin
          acc <= alu_res;
          if (step == '0) begin
            status <= fbpa_pkg::ST_OK;
            done   <= 1'b1;
            state  <= S_IDLE;
          end else begin
            step <= step - fbpa_pkg::STEP_W'(1);
          end
        end
        S_OFS: begin
          acc   <= alu_res;
          state <= S_CHK;
        end
        S_CHK: begin
          // offset at or beyond stride * 512 can never be in the pool
          quo  <= '0;
          step <= fbpa_pkg::STEP_W'(fbpa_pkg::QUO_W - 1);
          if (alu_carry) begin
            status <= fbpa_pkg::ST_BAD;
            done   <= 1'b1;
            state  <= S_IDLE;
          end else begin
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (alu_carry) begin
            acc       <= alu_res;
            quo[step] <= 1'b1;
          end
          if (step == '0) begin
            state <= S_REL;
          end else begin
            step <= step - fbpa_pkg::STEP_W'(1);
          end
        end
        S_REL: begin
          if (rel_bad) begin
            status <= fbpa_pkg::ST_BAD;
          end else begin
            status     <= fbpa_pkg::ST_OK;
            free_head  <= quo[fbpa_pkg::IDX_W-1:0];
            head_valid <= 1'b1;
            free_count <= free_count + fbpa_pkg::CNT_W'(1);
          end
          done  <= 1'b1;
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // result payload
  logic [AW-1:0] granted;
  assign granted = (op == fbpa_pkg::FUNC_ALLOC && status == fbpa_pkg::ST_OK) ? acc : '0;

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {5'd0, free_count, granted, status};
    end
  end

endmodule

// File: tb/tb_fixed_block_pool_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_fixed_block_pool_allocator
// self-checking bench for the block pool allocator: a queue-fed stream driver,
// a randomly stalling result sink, and a transaction-level model of the pool that
// predicts status, granted address and free count for every transaction
// ----------------------------------------------------------------------------
module tb_fixed_block_pool_allocator;

  localparam int LIMIT_CYCLES = 200000;  // far above the slowest legal run
  localparam int DRAIN_CYCLES = 20;      // settling margin after the last result
  localparam int LONG_HOLD    = 300;     // sink stall that backs up the input
  localparam int PHASE_ITEMS  = 58;

  typedef struct packed {
    logic [fbpa_pkg::STAT_W-1:0] status;
    logic [fbpa_pkg::ADDR_W-1:0] granted;
    logic [fbpa_pkg::CNT_W-1:0]  free_blocks;
  } pool_reply_t;

  typedef struct {
    logic        op;
    logic [31:0] addr;
  } pool_req_t;

  logic                           clk       = 1'b0;
  logic                           rst       = 1'b1;
  logic                           s_tvalid  = 1'b0;
  logic                           s_tready;
  logic [31:0]                    s_tdata   = '0;   // [31:0] block_addr
  logic                           s_tuser   = 1'b0; // [0] func
  logic                           m_tvalid;
  logic                           m_tready  = 1'b0;
  logic [47:0]                    m_tdata;          // [1:0] status, [33:2] granted_addr,
                                                    // [42:34] free_blocks, rest zero
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [fbpa_pkg::CFG_IDX_W-1:0] cfg_index = fbpa_pkg::CFG_POOL_BASE;
  logic [31:0]                    cfg_data  = '0;

  fixed_block_pool_allocator dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // pool model: register copies, free list, bump index, free count
  // --------------------------------------------------------------------------
  logic [31:0]                base_q  = '0;
  logic [15:0]                size_q  = 16'd4;
  logic [8:0]                 count_q = 9'd256;
  logic [fbpa_pkg::IDX_W-1:0] head_q  = '0;
  logic                       head_ok = 1'b0;
  logic [fbpa_pkg::IDX_W-1:0] next_link [fbpa_pkg::MAX_BLOCKS];
  logic                       next_ok   [fbpa_pkg::MAX_BLOCKS];
  logic [fbpa_pkg::CNT_W-1:0] unused_q = '0;
  logic [fbpa_pkg::CNT_W-1:0] free_q   = fbpa_pkg::CNT_W'(fbpa_pkg::MAX_BLOCKS);

  pool_req_t   pending [$];      // items waiting for the driver
  pool_reply_t replies_due [$];  // predicted replies, oldest first

  logic in_fire  = 1'b0;  // input transaction at the last rising edge
  int   errors   = 0;
  int   cycles   = 0;
  int   hold_req = 0;     // bumped to ask the sink for one long stall
  bit   no_idle  = 1'b0;  // final stretch runs both sides flat out

  // oversized counts saturate at the pool capacity
  function automatic int pool_blocks();
    return (count_q > fbpa_pkg::MAX_BLOCKS) ? fbpa_pkg::MAX_BLOCKS : int'(count_q);
  endfunction

  // zero size counts as one byte, then round up to the word unit
  function automatic int pool_stride();
    int s;
    s = (size_q == 16'd0) ? 1 : int'(size_q);
    return ((s + fbpa_pkg::ROUND_BYTES - 1) / fbpa_pkg::ROUND_BYTES) * fbpa_pkg::ROUND_BYTES;
  endfunction

  // a write to any of the three registers empties the list and refills the count
  function automatic void reset_pool();
    head_ok  = 1'b0;
    head_q   = '0;
    unused_q = '0;
    free_q   = fbpa_pkg::CNT_W'(pool_blocks());
  endfunction

  function automatic void set_register(logic [fbpa_pkg::CFG_IDX_W-1:0] index,
                                       logic [31:0] value);
    case (index)
      fbpa_pkg::CFG_POOL_BASE:   base_q = value;
      fbpa_pkg::CFG_BLOCK_SIZE:  size_q = value[15:0];
      fbpa_pkg::CFG_BLOCK_COUNT: count_q = value[8:0];
      default:                   return;
    endcase
    reset_pool();
  endfunction

  function automatic pool_reply_t pool_reply(logic op, logic [31:0] addr);
    pool_reply_t r;
    int          blocks;
    int          stride;
    int          idx;
    longint      off;
    longint      span;
    blocks   = pool_blocks();
    stride   = pool_stride();
    r        = '0;
    r.status = fbpa_pkg::ST_OK;
    if (op == fbpa_pkg::FUNC_ALLOC) begin
      idx = -1;
      if (free_q != '0) begin
        if (head_ok) begin
          // pop the most recently released block
          idx     = int'(head_q);
          head_q  = next_link[idx];
          head_ok = next_ok[idx];
        end else if (unused_q < blocks) begin
          // list empty: bump into the never-used area
          idx      = int'(unused_q);
          unused_q = unused_q + fbpa_pkg::CNT_W'(1);
        end
      end
      if (idx >= 0) begin
        free_q    = free_q - fbpa_pkg::CNT_W'(1);
        r.granted = base_q + 32'(longint'(idx) * stride);
      end else begin
        r.status = fbpa_pkg::ST_EMPTY;
      end
    end else begin
      // offset wraps modulo the address width
      off  = {32'b0, addr - base_q};
      span = longint'(stride) * blocks;
      if (free_q >= blocks || off >= span || (off % stride) != 0) begin
        r.status = fbpa_pkg::ST_BAD;
      end else begin
        idx            = int'(off / stride);
        next_link[idx] = head_q;
        next_ok[idx]   = head_ok;
        head_q         = fbpa_pkg::IDX_W'(idx);
        head_ok        = 1'b1;
        free_q         = free_q + fbpa_pkg::CNT_W'(1);
      end
    end
    r.free_blocks = free_q;
    return r;
  endfunction

  // mostly aligned in-pool addresses, then misaligned, edges and noise
  function automatic logic [31:0] pick_release_addr();
    int          blocks;
    int          stride;
    int          pick;
    logic [31:0] a;
    blocks = pool_blocks();
    stride = pool_stride();
    pick   = $urandom_range(0, 99);
    if (blocks == 0 || pick >= 85) begin
      a = $urandom();
    end else if (pick < 65) begin
      a = base_q + 32'($urandom_range(0, blocks - 1) * stride);
    end else if (pick < 75) begin
      a = base_q + 32'($urandom_range(0, blocks - 1) * stride)
          + 32'($urandom_range(1, stride - 1));
    end else if (pick < 80) begin
      a = base_q + 32'(blocks * stride);  // one past the last block
    end else begin
      a = base_q - 32'($urandom_range(1, stride));  // just below the pool
    end
    return a;
  endfunction

  // --------------------------------------------------------------------------
  // input driver: one item per transaction, random gaps between items
  // --------------------------------------------------------------------------
  int src_gap = 0;

  always @(negedge clk) begin : feed_items
    pool_req_t req;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || in_fire) begin
      if (src_gap > 0) begin
        src_gap--;
        s_tvalid <= 1'b0;
      end else if (pending.size() != 0) begin
        req = pending.pop_front();
        s_tvalid <= 1'b1;
        s_tuser  <= req.op;
        s_tdata  <= req.addr;
        if (!no_idle && $urandom_range(0, 3) == 0) src_gap = $urandom_range(1, 4);
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // result sink: short random stalls outside the final stretch, plus one long stall on request
  // --------------------------------------------------------------------------
  int sink_gap  = 0;
  int sink_hold = 0;
  int hold_seen = 0;

  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (hold_seen != hold_req) begin
        hold_seen = hold_req;
        sink_hold = LONG_HOLD;
      end
      if (sink_hold > 0) begin
        sink_hold--;
        m_tready <= 1'b0;
      end else if (sink_gap > 0) begin
        sink_gap--;
        m_tready <= 1'b0;
      end else if (!no_idle && $urandom_range(0, 5) == 0) begin
        sink_gap = $urandom_range(0, 3);  // start a short stall burst
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // monitor: predict on every input transaction, check every result
  // --------------------------------------------------------------------------
  task automatic check_field(string name, logic [47:0] want, logic [47:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin : watch_ports
    pool_reply_t want;
    if (rst) begin
      in_fire <= 1'b0;
    end else begin
      in_fire <= s_tvalid && s_tready;
      if (s_tvalid && s_tready) replies_due.push_back(pool_reply(s_tuser, s_tdata));
      if (m_tvalid && m_tready) begin
        if (replies_due.size() == 0) begin
          $display("%0t: result with nothing pending, expected none, got %h",
                   $time, m_tdata);
          errors++;
        end else begin
          want = replies_due.pop_front();
          check_field("status", want.status, m_tdata[1:0]);
          check_field("granted_addr", want.granted, m_tdata[33:2]);
          check_field("free_blocks", want.free_blocks, m_tdata[42:34]);
          check_field("padding", '0, m_tdata[47:43]);
        end
      end
    end
  end

  // watchdog on a hung handshake or a lost result
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT_CYCLES) begin
      $display("fixed_block_pool_allocator verification failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // stimulus
  // --------------------------------------------------------------------------
  task automatic push_req(logic op, logic [31:0] addr);
    pool_req_t r;
    r.op   = op;
    r.addr = addr;
    pending.push_back(r);
  endtask

  task automatic queue_random(int n, int alloc_pct);
    repeat (n) begin
      if ($urandom_range(0, 99) < alloc_pct) push_req(fbpa_pkg::FUNC_ALLOC, $urandom());
      else push_req(fbpa_pkg::FUNC_RELEASE, pick_release_addr());
    end
  endtask

  // nothing queued, nothing offered, nothing outstanding, then a margin
  task automatic wait_idle();
    do @(posedge clk); while (pending.size() != 0 || s_tvalid || replies_due.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [fbpa_pkg::CFG_IDX_W-1:0] index, logic [31:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    set_register(index, value);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // unused upper data bits carry junk, the block must ignore them
  task automatic configure(logic [31:0] base, logic [15:0] size, logic [8:0] count);
    logic [31:0] junk;
    junk = $urandom();
    write_reg(fbpa_pkg::CFG_BLOCK_SIZE, {junk[31:16], size});
    write_reg(fbpa_pkg::CFG_BLOCK_COUNT, {junk[22:0], count});
    write_reg(fbpa_pkg::CFG_POOL_BASE, base);
    @(posedge clk);
  endtask

  initial begin
    logic [31:0] base;
    logic [15:0] size;
    logic [8:0]  count;
    int          pct;
    for (int i = 0; i < fbpa_pkg::MAX_BLOCKS; i++) begin
      next_link[i] = '0;
      next_ok[i]   = 1'b0;
    end
    reset_pool();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset defaults: base 0, stride 4, 256 blocks
    push_req(fbpa_pkg::FUNC_RELEASE, 32'h0000_0000);  // pool full right after reset
    push_req(fbpa_pkg::FUNC_ALLOC,   32'hFFFF_FFFF);  // address ignored on allocate
    push_req(fbpa_pkg::FUNC_RELEASE, 32'h0000_0002);  // off the block boundary
    push_req(fbpa_pkg::FUNC_RELEASE, 32'h0000_0400);  // one past the pool
    push_req(fbpa_pkg::FUNC_RELEASE, 32'h0000_0000);
    push_req(fbpa_pkg::FUNC_ALLOC,   32'h0000_0000);  // comes back off the list
    push_req(fbpa_pkg::FUNC_ALLOC,   32'h0000_0000);  // bump index

    // three blocks that wrap past the top of the address space
    wait_idle();
    configure(32'hFFFF_FFF8, 16'd5, 9'd3);
    repeat (4) push_req(fbpa_pkg::FUNC_ALLOC, 32'h0);  // last one finds the pool empty
    push_req(fbpa_pkg::FUNC_RELEASE, 32'h0000_0008);
    push_req(fbpa_pkg::FUNC_RELEASE, 32'h0000_0008);  // double release is accepted
    push_req(fbpa_pkg::FUNC_ALLOC,   32'h0);
    push_req(fbpa_pkg::FUNC_ALLOC,   32'h0);           // same block handed out twice
    push_req(fbpa_pkg::FUNC_RELEASE, 32'h0000_0010);

    // zero-block pool
    wait_idle();
    configure(32'h0000_0100, 16'd4, 9'd0);
    push_req(fbpa_pkg::FUNC_ALLOC,   32'h0);
    push_req(fbpa_pkg::FUNC_RELEASE, 32'h0000_0100);

    // saturated count with the largest block size
    wait_idle();
    configure(32'h0000_0000, 16'hFFFF, 9'h1FF);
    push_req(fbpa_pkg::FUNC_ALLOC,   32'h0);
    push_req(fbpa_pkg::FUNC_ALLOC,   32'h0);
    push_req(fbpa_pkg::FUNC_RELEASE, 32'h00FF_0000);  // last block of the pool
    push_req(fbpa_pkg::FUNC_ALLOC,   32'h0);

    // zero size rounds to one word
    wait_idle();
    configure(32'h0000_0040, 16'd0, 9'd1);
    push_req(fbpa_pkg::FUNC_ALLOC,   32'h0);
    push_req(fbpa_pkg::FUNC_ALLOC,   32'h0);

    // random phases, each with its own pool shape
    for (int p = 0; p < 12; p++) begin
      base  = $urandom();
      size  = 16'($urandom_range(1, 65535));
      count = 9'($urandom_range(1, 40));
      pct   = $urandom_range(35, 65);
      case (p)
        0:  begin base = 32'h0000_1000; size = 16'd12; count = 9'd4; end
        1:  begin base = 32'hFFFF_FFFF; size = 16'd1;  count = 9'd2; end
        2:  begin size = 16'd0; count = 9'd1; end
        3:  begin base = 32'h0000_0000; size = 16'hFFFF; count = 9'd8; end
        4:  begin count = 9'd256; pct = 60; end
        5:  begin size = 16'd3; count = 9'h1FF; end
        6:  begin size = 16'($urandom_range(1, 64)); count = 9'($urandom_range(2, 12)); end
        7:  begin base = 32'h8000_0000; size = 16'd100; count = 9'd16; pct = 40; end
        9:  begin size = 16'd4; count = 9'd0; end
        10: count = 9'($urandom_range(257, 511));
        11: begin size = 16'($urandom_range(1, 32)); count = 9'($urandom_range(3, 10)); end
        default: ;
      endcase
      wait_idle();
      configure(base, size, count);
      if (p == 11) no_idle = 1'b1;
      if (p == 5) begin
        // sender pauses mid-phase until every reply is back
        queue_random(PHASE_ITEMS / 2, pct);
        wait_idle();
        queue_random(PHASE_ITEMS - PHASE_ITEMS / 2, pct);
      end else begin
        queue_random(PHASE_ITEMS, pct);
      end
      // sink stalls while the driver keeps offering items
      if (p == 2) hold_req++;
    end

    wait_idle();
    if (errors == 0) begin
      $display("fixed_block_pool_allocator verification clean");
    end else begin
      $display("fixed_block_pool_allocator verification failed");
    end
    $finish;
  end

endmodule
